// ----- rtl/ptms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptms_pkg
// Shared types and codes of the PDU transmit mode scheduler.
// ----------------------------------------------------------------------------
package ptms_pkg;

	localparam int PDU_W = 6;
	localparam int CNT_W = 8;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_SEND = 2'd1;
	localparam logic [1:0] ACT_SELECT = 2'd2;
	localparam logic [1:0] ACT_START = 2'd3;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_PERIODIC = 2'd1;
	localparam logic [1:0] MODE_MIXED = 2'd2;
	localparam logic [1:0] MODE_DIRECT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE_TRUE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TRUE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_TRUE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_FALSE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_FALSE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_FALSE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE = 3'd7;

	typedef struct packed {
		logic [1:0] action;
		logic [PDU_W-1:0] pdu_index;
		logic [CNT_W-1:0] repeat_count;
		logic flag_value;
	} req_t;

	typedef struct packed {
		logic [PDU_W-1:0] pdu_out;
		logic [1:0] send_triggers;
		logic deadline_timeout;
		logic [CNT_W-1:0] repeats_left;
	} rsp_t;

	typedef struct packed {
		logic [1:0] action;
		logic [PDU_W-1:0] pdu;
		logic in_range;
		logic [CNT_W-1:0] cnt;
		logic flag;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode_true;
		logic [CFG_W-1:0] period_true;
		logic [CFG_W-1:0] gap_true;
		logic [1:0] mode_false;
		logic [CFG_W-1:0] period_false;
		logic [CFG_W-1:0] gap_false;
		logic [CFG_W-1:0] min_delay;
		logic [CFG_W-1:0] deadline;
	} cfg_t;

endpackage
`default_nettype wire

// ----- rtl/ptms_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ptms_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptms_front
// Request intake: range check of the PDU index and a two-entry command queue.
// ----------------------------------------------------------------------------
module ptms_front
	import ptms_pkg::*;
#(
	parameter int NUM_PDUS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic req_stall,
	input  wire req_t req,
	input  wire logic busy,
	output logic cmd_valid,
	output cmd_t cmd,
	input  wire logic cmd_pop
);

	cmd_t q_mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	cmd_t new_cmd;

	assign req_stall = busy || (cnt_q == 2'd2);
	assign push = req_valid && !req_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_mem_q[rd_ptr_q];

	always_comb begin
		new_cmd.action = req.action;
		new_cmd.pdu = req.pdu_index;
		new_cmd.in_range = (32'(req.pdu_index) < 32'(NUM_PDUS));
		new_cmd.cnt = req.repeat_count;
		new_cmd.flag = req.flag_value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (cmd_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

// ----- rtl/ptms_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptms_back
// Execution: clearing pass, read-modify-write of one PDU entry, result register.
// ----------------------------------------------------------------------------
module ptms_back
	import ptms_pkg::*;
#(
	parameter int NUM_PDUS = 64,
	parameter int TIMER_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic cmd_pop,
	output logic busy,
	output logic rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t rsp
);

	localparam int ADDR_W = NUM_PDUS > 1 ? $clog2(NUM_PDUS) : 1;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	typedef struct packed {
		logic [TIMER_BITS-1:0] per;
		logic [TIMER_BITS-1:0] rpt;
		logic [TIMER_BITS-1:0] dly;
		logic [TIMER_BITS-1:0] ddl;
		logic [CNT_W-1:0] rem;
		logic msel;
		logic started;
	} ent_t;

	logic [1:0] state_q;
	logic [ADDR_W-1:0] clr_q;
	cmd_t cmd_q;
	logic out_valid_q;
	rsp_t rsp_q;

	ent_t ent;
	ent_t nxt;
	logic [$bits(ent_t)-1:0] rdata;
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [$bits(ent_t)-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;

	logic sel;
	logic [1:0] mode;
	logic [TIMER_BITS-1:0] period;
	logic [TIMER_BITS-1:0] gap;
	logic [TIMER_BITS-1:0] dl;
	logic [TIMER_BITS-1:0] md;
	logic tmo;
	logic [1:0] sends;
	rsp_t nxt_rsp;

	assign busy = (state_q == ST_CLEAR);
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid && (!out_valid_q || !rsp_stall);
	assign ram_raddr = ADDR_W'(cmd.pdu);
	assign ent = ent_t'(rdata);
	assign rsp_valid = out_valid_q;
	assign rsp = rsp_q;

	ptms_ram #(
		.WIDTH($bits(ent_t)),
		.DEPTH(NUM_PDUS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(cmd_pop),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_comb begin
		sel = ent.msel;
		mode = sel ? cfg.mode_true : cfg.mode_false;
		period = TIMER_BITS'(sel ? cfg.period_true : cfg.period_false);
		gap = TIMER_BITS'(sel ? cfg.gap_true : cfg.gap_false);
		dl = TIMER_BITS'(cfg.deadline);
		md = TIMER_BITS'(cfg.min_delay);
		nxt = ent;
		tmo = 1'b0;
		sends = 2'd0;
		case (cmd_q.action)
			ACT_TICK: begin
				if (ent.started) begin
					nxt.dly = (ent.dly != '0) ? ent.dly - 1'b1 : '0;
					if (dl != '0 && ent.ddl != '0) begin
						nxt.ddl = ent.ddl - 1'b1;
						tmo = (nxt.ddl == '0);
					end
					if (mode inside {MODE_PERIODIC, MODE_MIXED}) begin
						nxt.per = (ent.per != '0) ? ent.per - 1'b1 : '0;
					end
					if ((mode inside {MODE_MIXED, MODE_DIRECT}) && ent.rem != '0) begin
						nxt.rpt = (ent.rpt != '0) ? ent.rpt - 1'b1 : '0;
						if (!tmo) begin
							if (nxt.rpt == '0 && nxt.dly == '0) begin
								sends = sends + 2'd1;
								nxt.rpt = gap;
								nxt.rem = ent.rem - 1'b1;
								nxt.dly = md;
							end
						end else begin
							nxt.rem = '0;
						end
					end
					if ((mode inside {MODE_PERIODIC, MODE_MIXED}) &&
						nxt.per == '0 && nxt.dly == '0) begin
						sends = sends + 2'd1;
						nxt.per = period;
						if (dl != '0 && nxt.ddl == '0) begin
							nxt.ddl = dl;
						end
						nxt.dly = md;
					end
				end
			end
			ACT_SEND: begin
				if (ent.started) begin
					nxt.rem = cmd_q.cnt;
					nxt.rpt = '0;
					if (dl != '0) begin
						nxt.ddl = dl;
					end
				end
			end
			ACT_SELECT: begin
				nxt.msel = cmd_q.flag;
			end
			default: begin
				nxt.started = cmd_q.flag;
			end
		endcase
		nxt_rsp.pdu_out = cmd_q.pdu;
		nxt_rsp.send_triggers = cmd_q.in_range ? sends : 2'd0;
		nxt_rsp.deadline_timeout = cmd_q.in_range && tmo;
		nxt_rsp.repeats_left = cmd_q.in_range ? nxt.rem : '0;
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we = (state_q == ST_EXEC) && cmd_q.in_range;
			ram_waddr = ADDR_W'(cmd_q.pdu);
			ram_wdata = nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_EXEC) begin
			rsp_q <= nxt_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(NUM_PDUS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_EXEC) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> !out_valid_q)
		else $error("result register occupied at execute");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!cmd_pop && !out_valid_q))
		else $error("request taken during clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && cmd_q.action != ACT_TICK) |->
		(nxt_rsp.send_triggers == 2'd0 && !nxt_rsp.deadline_timeout))
		else $error("send or timeout reported for a non-tick request");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && !cmd_q.in_range) |->
		(!ram_we && nxt_rsp.repeats_left == '0))
		else $error("out-of-range request touched the table");
`endif

endmodule
`default_nettype wire

// ----- rtl/pdu_tx_mode_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdu_tx_mode_scheduler
// Per-PDU transmit mode scheduler with a shared timing profile.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_stall, results leave on rsp_valid/rsp_stall;
// a transfer happens on a clock edge with valid high and stall low. Every
// request gives exactly one result, in request order.
// The front queues up to two requests; the back reads the PDU entry from the
// table RAM, updates it and writes it back. It takes a request only in its
// idle state (RAM read), then updates the entry and registers the result in
// its execute state, so it takes no new request until the last is written back.
// After reset the back clears all NUM_PDUS entries, one entry per cycle;
// req_stall stays high during that pass. Configuration writes on
// cfg_we/cfg_index/cfg_wdata take effect at once; the user must make them
// only while idle, as the block itself does not enforce it. When rsp_stall is
// high a pending result holds, the back stops taking requests while it holds
// one, and the queue fills before req_stall rises.
// ----------------------------------------------------------------------------
module pdu_tx_mode_scheduler
	import ptms_pkg::*;
#(
	parameter int NUM_PDUS = 64,
	parameter int TIMER_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic req_stall,
	input  wire req_t req,
	output logic rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t rsp,
	input  wire logic cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic busy;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE_TRUE: cfg_q.mode_true <= cfg_wdata[1:0];
				CFG_PERIOD_TRUE: cfg_q.period_true <= cfg_wdata;
				CFG_GAP_TRUE: cfg_q.gap_true <= cfg_wdata;
				CFG_MODE_FALSE: cfg_q.mode_false <= cfg_wdata[1:0];
				CFG_PERIOD_FALSE: cfg_q.period_false <= cfg_wdata;
				CFG_GAP_FALSE: cfg_q.gap_false <= cfg_wdata;
				CFG_MIN_DELAY: cfg_q.min_delay <= cfg_wdata;
				CFG_DEADLINE: cfg_q.deadline <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	ptms_front #(
		.NUM_PDUS(NUM_PDUS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.busy(busy),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	ptms_back #(
		.NUM_PDUS(NUM_PDUS),
		.TIMER_BITS(TIMER_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.busy(busy),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule
`default_nettype wire
